// ===== rtl/dqb_pkg.sv =====
// ============================================================================
// dqb_pkg : shared types and constants of the dns query builder
// Item layouts, register indexes, character codes and the command and status
// groups between the controller and the datapath.
// ============================================================================
`default_nettype none

package dqb_pkg;

	// default longest label
	localparam int LABEL_MAX_DEF = 63;

	// special characters of a dotted name
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_BSL = 8'h5C;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_RECURSION_DESIRED = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ID_BASE           = 1'b1;

	// fixed message parts
	localparam int HDR_BYTES  = 12;
	localparam int TAIL_BYTES = 5;
	localparam int SEQ_W      = 4;

	// byte count codes
	localparam logic [1:0] BC_ERR = 2'd0;
	localparam logic [1:0] BC_ONE = 2'd1;
	localparam logic [1:0] BC_TWO = 2'd2;

	typedef struct packed {
		logic        has_char;
		logic [7:0]  name_char;
		logic        is_last;
		logic [15:0] query_type;
		logic [15:0] query_class;
	} in_item_t;

	typedef struct packed {
		logic [7:0] byte_first;
		logic [7:0] byte_second;
		logic [1:0] byte_count;
		logic       message_end;
		logic       name_status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_HDR,
		ST_LEN,
		ST_LBL,
		ST_TAIL,
		ST_CLOSE,
		ST_ERR
	} ctrl_state_t;

	typedef enum logic [1:0] {
		SRC_HDR,
		SRC_LEN,
		SRC_LBL,
		SRC_TAIL
	} byte_src_t;

	// controller to datapath
	typedef struct packed {
		logic      accept;
		logic      set_in_msg;
		logic      set_esc;
		logic      clr_esc;
		logic      set_ld;
		logic      add_en;
		logic      add_bsl;
		logic      skip_set;
		logic      skip_clr;
		logic      cnt_inc;
		logic      clear_msg;
		byte_src_t src;
		logic      push;
		logic      push_last;
		logic      close;
		logic      err;
		logic      seq_inc;
		logic      seq_clr;
		logic      lidx_inc;
		logic      flush_done;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic has_char;
		logic is_last;
		logic is_dot;
		logic is_bsl;
		logic in_msg;
		logic esc;
		logic labels_done;
		logic any_label;
		logic skipping;
		logic len_zero;
		logic full;
		logic lbl_end;
		logic hdr_end;
		logic tail_end;
		logic room;
		logic pend;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/dqb_datapath.sv =====
// ============================================================================
// dqb_datapath : registers, label memory and byte packer of the query builder
// Holds the current item, the message flags, the label store, the byte
// sequencer sources and the pair packer with its output register.
// ============================================================================
`default_nettype none

module dqb_datapath #(
	parameter int LABEL_MAX = dqb_pkg::LABEL_MAX_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  dqb_pkg::in_item_t                 in_item,
	input  wire                               cfg_wr_en,
	input  wire [dqb_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire [dqb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  wire                               out_ready,
	output logic                              out_valid,
	output dqb_pkg::out_item_t                out_item,
	input  dqb_pkg::cmd_t                     cmd,
	output dqb_pkg::sts_t                     sts
);

	localparam int LEN_W = $clog2(LABEL_MAX + 1);
	localparam int AW    = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
	localparam int DEPTH = 1 << AW;

	dqb_pkg::in_item_t  item_q;
	logic               rd_q;
	logic [15:0]        id_base_q;
	logic [15:0]        counter_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   lidx_q;
	logic [LEN_W-1:0]   lidx_nx;
	logic               in_msg_q;
	logic               esc_q;
	logic               ld_q;
	logic               any_q;
	logic               skip_q;
	logic [dqb_pkg::SEQ_W-1:0] seq_q;
	logic [7:0]         mem [0:DEPTH-1];
	logic [7:0]         rdata_q;
	logic [AW-1:0]      rd_addr;
	logic [7:0]         add_byte;
	logic [15:0]        id;
	logic [7:0]         hdr_byte;
	logic [7:0]         tail_byte;
	logic [7:0]         cur_byte;
	logic               pend_q;
	logic [7:0]         pend_b_q;
	logic               out_valid_q;
	logic               load_out;
	dqb_pkg::out_item_t out_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= in_item;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q      <= 1'b1;
			id_base_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				dqb_pkg::CFG_RECURSION_DESIRED: rd_q      <= cfg_wdata[0];
				dqb_pkg::CFG_ID_BASE:           id_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// message flags and label length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			in_msg_q <= 1'b0;
			esc_q    <= 1'b0;
			ld_q     <= 1'b0;
			any_q    <= 1'b0;
		end else if (cmd.clear_msg) begin
			len_q    <= '0;
			in_msg_q <= 1'b0;
			esc_q    <= 1'b0;
			ld_q     <= 1'b0;
			any_q    <= 1'b0;
		end else begin
			if (cmd.set_in_msg) begin
				in_msg_q <= 1'b1;
			end
			if (cmd.clr_esc) begin
				esc_q <= 1'b0;
			end else if (cmd.set_esc) begin
				esc_q <= 1'b1;
			end
			if (cmd.set_ld) begin
				ld_q <= 1'b1;
			end
			if (cmd.add_en) begin
				len_q <= len_q + 1'b1;
			end else if (cmd.flush_done) begin
				len_q <= '0;
				any_q <= 1'b1;
			end
		end
	end

	// skip flag and per-name counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q    <= 1'b0;
			counter_q <= '0;
		end else begin
			if (cmd.skip_set) begin
				skip_q <= 1'b1;
			end else if (cmd.skip_clr) begin
				skip_q <= 1'b0;
			end
			if (cmd.cnt_inc) begin
				counter_q <= counter_q + 16'd1;
			end
		end
	end

	// sequence counters for header, tail and label reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= '0;
			lidx_q <= '0;
		end else begin
			if (cmd.seq_clr) begin
				seq_q <= '0;
			end else if (cmd.seq_inc) begin
				seq_q <= seq_q + 1'b1;
			end
			if (cmd.flush_done) begin
				lidx_q <= '0;
			end else if (cmd.lidx_inc) begin
				lidx_q <= lidx_nx;
			end
		end
	end

	assign lidx_nx  = lidx_q + 1'b1;
	assign rd_addr  = cmd.lidx_inc ? lidx_nx[AW-1:0] : lidx_q[AW-1:0];
	assign add_byte = cmd.add_bsl ? dqb_pkg::CH_BSL : item_q.name_char;

	// label store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.add_en) begin
			mem[len_q[AW-1:0]] <= add_byte;
		end
		rdata_q <= mem[rd_addr];
	end

	// header and tail bytes
	assign id = id_base_q + counter_q;

	always_comb begin
		case (seq_q)
			4'd0:    hdr_byte = id[15:8];
			4'd1:    hdr_byte = id[7:0];
			4'd2:    hdr_byte = {7'd0, rd_q};
			4'd5:    hdr_byte = 8'd1;
			default: hdr_byte = 8'd0;
		endcase
	end

	always_comb begin
		case (seq_q)
			4'd1:    tail_byte = item_q.query_type[15:8];
			4'd2:    tail_byte = item_q.query_type[7:0];
			4'd3:    tail_byte = item_q.query_class[15:8];
			4'd4:    tail_byte = item_q.query_class[7:0];
			default: tail_byte = 8'd0;
		endcase
	end

	// byte source select
	always_comb begin
		unique case (cmd.src)
			dqb_pkg::SRC_HDR:  cur_byte = hdr_byte;
			dqb_pkg::SRC_LEN:  cur_byte = 8'(len_q);
			dqb_pkg::SRC_LBL:  cur_byte = rdata_q;
			dqb_pkg::SRC_TAIL: cur_byte = tail_byte;
			default:           cur_byte = 8'd0;
		endcase
	end

	// output register takes a new item on a full pair, a lone byte or an error
	assign load_out = (cmd.push && (pend_q || cmd.push_last)) || (cmd.close && pend_q)
		|| cmd.err;

	// pair packer control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.push) begin
				pend_q <= !pend_q && !cmd.push_last;
			end else if (cmd.close) begin
				pend_q <= 1'b0;
			end
		end
	end

	// pair packer payload
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (pend_q) begin
				out_q <= '{byte_first: pend_b_q, byte_second: cur_byte,
					byte_count: dqb_pkg::BC_TWO, message_end: cmd.push_last,
					name_status: 1'b0};
			end else if (cmd.push_last) begin
				out_q <= '{byte_first: cur_byte, byte_second: 8'd0,
					byte_count: dqb_pkg::BC_ONE, message_end: 1'b1,
					name_status: 1'b0};
			end else begin
				pend_b_q <= cur_byte;
			end
		end
		if (cmd.close && pend_q) begin
			out_q <= '{byte_first: pend_b_q, byte_second: 8'd0,
				byte_count: dqb_pkg::BC_ONE, message_end: 1'b0, name_status: 1'b0};
		end
		if (cmd.err) begin
			out_q <= '{byte_first: 8'd0, byte_second: 8'd0,
				byte_count: dqb_pkg::BC_ERR, message_end: 1'b1, name_status: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// status towards the controller
	always_comb begin
		sts.has_char    = item_q.has_char;
		sts.is_last     = item_q.is_last;
		sts.is_dot      = (item_q.name_char == dqb_pkg::CH_DOT);
		sts.is_bsl      = (item_q.name_char == dqb_pkg::CH_BSL);
		sts.in_msg      = in_msg_q;
		sts.esc         = esc_q;
		sts.labels_done = ld_q;
		sts.any_label   = any_q;
		sts.skipping    = skip_q;
		sts.len_zero    = (len_q == '0);
		sts.full        = (len_q >= LEN_W'(LABEL_MAX));
		sts.lbl_end     = (lidx_nx == len_q);
		sts.hdr_end     = (seq_q == dqb_pkg::SEQ_W'(dqb_pkg::HDR_BYTES - 1));
		sts.tail_end    = (seq_q == dqb_pkg::SEQ_W'(dqb_pkg::TAIL_BYTES - 1));
		sts.room        = !out_valid_q || out_ready;
		sts.pend        = pend_q;
	end

endmodule

`default_nettype wire

// ===== rtl/dqb_ctrl.sv =====
// ============================================================================
// dqb_ctrl : controller of the dns query builder
// Decodes each item against the message flags and then steps the datapath
// through header, label flush, tail, pair close and error result.
// ============================================================================
`default_nettype none

module dqb_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  dqb_pkg::sts_t        sts,
	output dqb_pkg::cmd_t        cmd
);

	dqb_pkg::ctrl_state_t state_q;
	dqb_pkg::ctrl_state_t state_d;
	logic flush_q, tail_q, bad_q;
	logic flush_d, tail_d, bad_d;

	// state and plan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqb_pkg::ST_IDLE;
			flush_q <= 1'b0;
			tail_q  <= 1'b0;
			bad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			flush_q <= flush_d;
			tail_q  <= tail_d;
			bad_q   <= bad_d;
		end
	end

	// next state and commands
	always_comb begin
		logic bad1, add_chr, set_esc, clr_esc_c, set_ld, flush_dot;
		logic esc_after, trail, bad2, bad, add_any, tail, flush;

		// character decode
		bad1      = 1'b0;
		add_chr   = 1'b0;
		set_esc   = 1'b0;
		clr_esc_c = 1'b0;
		set_ld    = 1'b0;
		flush_dot = 1'b0;
		if (sts.has_char) begin
			if (sts.labels_done) begin
				bad1 = 1'b1;
			end else if (sts.esc) begin
				clr_esc_c = 1'b1;
				add_chr   = 1'b1;
				bad1      = sts.full;
			end else if (sts.is_bsl) begin
				set_esc = 1'b1;
			end else if (sts.is_dot) begin
				if (sts.len_zero) begin
					if (sts.any_label) begin
						bad1 = 1'b1;
					end else begin
						set_ld = 1'b1;
					end
				end else begin
					flush_dot = 1'b1;
				end
			end else begin
				add_chr = 1'b1;
				bad1    = sts.full;
			end
		end

		// end of name: trailing backslash, final flush and tail
		esc_after = sts.has_char ? set_esc : sts.esc;
		trail     = !bad1 && sts.is_last && esc_after;
		bad2      = trail && sts.full;
		bad       = bad1 || bad2;
		add_any   = (add_chr && !bad1) || (trail && !bad2);
		tail      = !bad && sts.is_last;
		flush     = flush_dot || (tail && (!sts.len_zero || add_any));

		cmd      = '0;
		cmd.src  = dqb_pkg::SRC_HDR;
		in_ready = 1'b0;
		state_d  = state_q;
		flush_d  = flush_q;
		tail_d   = tail_q;
		bad_d    = bad_q;

		unique case (state_q)
			dqb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = dqb_pkg::ST_DECIDE;
				end
			end
			dqb_pkg::ST_DECIDE: begin
				if (sts.skipping) begin
					if (sts.is_last) begin
						cmd.skip_clr = 1'b1;
						cmd.cnt_inc  = 1'b1;
					end
					state_d = dqb_pkg::ST_IDLE;
				end else begin
					cmd.set_in_msg = !sts.in_msg;
					cmd.set_esc    = set_esc;
					cmd.clr_esc    = clr_esc_c || trail;
					cmd.set_ld     = set_ld;
					cmd.add_en     = add_any;
					cmd.add_bsl    = trail;
					flush_d        = flush;
					tail_d         = tail;
					bad_d          = bad;
					if (!sts.in_msg) begin
						state_d = dqb_pkg::ST_HDR;
					end else if (flush) begin
						state_d = dqb_pkg::ST_LEN;
					end else if (tail) begin
						state_d = dqb_pkg::ST_TAIL;
					end else if (bad) begin
						state_d = dqb_pkg::ST_ERR;
					end else begin
						state_d = dqb_pkg::ST_IDLE;
					end
				end
			end
			dqb_pkg::ST_HDR: begin
				cmd.src = dqb_pkg::SRC_HDR;
				if (sts.room) begin
					cmd.push    = 1'b1;
					cmd.seq_inc = 1'b1;
					if (sts.hdr_end) begin
						cmd.seq_clr = 1'b1;
						if (flush_q) begin
							state_d = dqb_pkg::ST_LEN;
						end else if (tail_q) begin
							state_d = dqb_pkg::ST_TAIL;
						end else begin
							state_d = dqb_pkg::ST_CLOSE;
						end
					end
				end
			end
			dqb_pkg::ST_LEN: begin
				cmd.src = dqb_pkg::SRC_LEN;
				if (sts.room) begin
					cmd.push = 1'b1;
					state_d  = dqb_pkg::ST_LBL;
				end
			end
			dqb_pkg::ST_LBL: begin
				cmd.src = dqb_pkg::SRC_LBL;
				if (sts.room) begin
					cmd.push     = 1'b1;
					cmd.lidx_inc = 1'b1;
					if (sts.lbl_end) begin
						cmd.flush_done = 1'b1;
						state_d = tail_q ? dqb_pkg::ST_TAIL : dqb_pkg::ST_CLOSE;
					end
				end
			end
			dqb_pkg::ST_TAIL: begin
				cmd.src = dqb_pkg::SRC_TAIL;
				if (sts.room) begin
					cmd.push      = 1'b1;
					cmd.seq_inc   = 1'b1;
					cmd.push_last = sts.tail_end;
					if (sts.tail_end) begin
						cmd.seq_clr   = 1'b1;
						cmd.clear_msg = 1'b1;
						cmd.cnt_inc   = 1'b1;
						state_d       = dqb_pkg::ST_IDLE;
					end
				end
			end
			dqb_pkg::ST_CLOSE: begin
				if (sts.room) begin
					cmd.close = 1'b1;
					state_d   = bad_q ? dqb_pkg::ST_ERR : dqb_pkg::ST_IDLE;
				end
			end
			dqb_pkg::ST_ERR: begin
				if (sts.room) begin
					cmd.err       = 1'b1;
					cmd.clear_msg = 1'b1;
					cmd.cnt_inc   = sts.is_last;
					cmd.skip_set  = !sts.is_last;
					state_d       = dqb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dqb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/dns_query_builder.sv =====
// Flow: each taken item is decoded in ST_DECIDE, then its bytes are packed one a
// cycle while the output has room: the 12 header bytes of a new message, a length
// byte and the label bytes per label flush, the 5 tail bytes, then a pair close
// or an error result. The next item is taken only once the last one is through;
// the label store is read a byte a cycle.
// Reset: control state, flags and query counter clear, RD reads 1; no label clear.
// ============================================================================
// dns_query_builder : streaming dns query message encoder
// Turns a dotted name, one character per item, into a query message carried
// as byte pairs: header, length-prefixed labels, root byte, type and class.
// ============================================================================
`default_nettype none

module dns_query_builder #(
	parameter int LABEL_MAX = dqb_pkg::LABEL_MAX_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  dqb_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  wire                            out_ready,
	output dqb_pkg::out_item_t             out_item,
	input  wire                            cfg_wr_en,
	input  wire [dqb_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  wire [dqb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	dqb_pkg::cmd_t cmd;
	dqb_pkg::sts_t sts;

	// sequencing
	dqb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// storage and byte path
	dqb_datapath #(
		.LABEL_MAX (LABEL_MAX)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.sts       (sts)
	);

	// no half pair may be left over when a new item is taken
	a_no_pend_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !sts.pend)
		else $error("byte pair left open between items");

	// skipping a bad name never overlaps an open message
	a_skip_no_msg: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.skipping && sts.in_msg))
		else $error("skipping while a message is open");

	// an error result carries no bytes and ends the message
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.name_status) |->
			(out_item.byte_count == dqb_pkg::BC_ERR && out_item.message_end))
		else $error("malformed error result");

	// a push is never commanded together with an error result or a pair close
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && (cmd.err || cmd.close)))
		else $error("two loads of the output register at once");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top : testbench of the dns query builder
// Feeds dotted names one character per item through the valid/ready input and
// checks every byte pair that comes out against a predictor of the query
// encoder kept in the testbench. It runs directed names, long labels and
// random names under several register settings, with random stalls on both
// sides.
// ============================================================================

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE_CYCLES = 20;

	// clock, reset and block ports
	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	dqb_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	dqb_pkg::out_item_t out_item;
	logic cfg_wr_en = 1'b0;
	logic [dqb_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
	logic [dqb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	// items waiting to go in and byte pairs due to come out
	dqb_pkg::in_item_t char_items[$];
	dqb_pkg::out_item_t msg_pairs_due[$];
	logic [7:0] msg_bytes[$];
	logic [7:0] name_buf[$];

	// predictor state
	logic [7:0] lbl_buf [0:62];
	int unsigned lbl_len;
	bit in_msg;
	bit esc_pend;
	bit root_seen;
	bit skipping;
	bit label_emitted;
	logic [15:0] qcount;
	bit rd_bit;
	logic [15:0] id_base_r;

	// run control
	bit gaps_on;
	bit add_blanks;
	int items_made;
	int bad_pairs;
	int cycle_count = 0;
	int send_gap;
	int hold_cnt;
	dqb_pkg::out_item_t want;

	dns_query_builder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// queue appends
	function automatic void put_byte(logic [7:0] b);
		msg_bytes.insert(msg_bytes.size(), b);
	endfunction

	function automatic void add_pair(dqb_pkg::out_item_t p);
		msg_pairs_due.insert(msg_pairs_due.size(), p);
	endfunction

	function automatic void add_item(dqb_pkg::in_item_t it);
		char_items.insert(char_items.size(), it);
	endfunction

	function automatic void add_name_byte(logic [7:0] b);
		name_buf.insert(name_buf.size(), b);
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic void clear_msg();
		lbl_len = 0;
		in_msg = 1'b0;
		esc_pend = 1'b0;
		root_seen = 1'b0;
		label_emitted = 1'b0;
	endfunction

	function automatic bit store_char(logic [7:0] c);
		if (lbl_len >= dqb_pkg::LABEL_MAX_DEF)
			return 1'b0;
		lbl_buf[lbl_len] = c;
		lbl_len++;
		return 1'b1;
	endfunction

	function automatic void flush_label();
		put_byte(8'(lbl_len));
		for (int i = 0; i < lbl_len; i++)
			put_byte(lbl_buf[i]);
		lbl_len = 0;
		label_emitted = 1'b1;
	endfunction

	// message bytes of one item go out two at a time, an odd one alone
	function automatic void pack_bytes(bit end_flag);
		int i;
		dqb_pkg::out_item_t p;
		i = 0;
		while (i < msg_bytes.size()) begin
			p.byte_first = msg_bytes[i];
			if (i + 1 < msg_bytes.size()) begin
				p.byte_second = msg_bytes[i + 1];
				p.byte_count = dqb_pkg::BC_TWO;
				i += 2;
			end else begin
				p.byte_second = 8'h00;
				p.byte_count = dqb_pkg::BC_ONE;
				i += 1;
			end
			p.message_end = end_flag && (i >= msg_bytes.size());
			p.name_status = 1'b0;
			add_pair(p);
		end
	endfunction

	// works out the byte pairs that one accepted item causes
	function automatic void encode_item(dqb_pkg::in_item_t it);
		bit bad;
		logic [15:0] id;
		dqb_pkg::out_item_t e;
		bad = 1'b0;
		msg_bytes.delete();

		// bad name: drop everything up to the last item
		if (skipping) begin
			if (it.is_last) begin
				skipping = 1'b0;
				qcount++;
			end
			return;
		end

		// header on the first item of a name
		if (!in_msg) begin
			id = id_base_r + qcount;
			put_byte(id[15:8]);
			put_byte(id[7:0]);
			put_byte({7'd0, rd_bit});
			put_byte(8'h00);
			put_byte(8'h00);
			put_byte(8'h01);
			repeat (6) put_byte(8'h00);
			in_msg = 1'b1;
		end

		// character handling
		if (it.has_char) begin
			if (root_seen) begin
				bad = 1'b1;
			end else if (esc_pend) begin
				esc_pend = 1'b0;
				bad = !store_char(it.name_char);
			end else if (it.name_char == dqb_pkg::CH_BSL) begin
				esc_pend = 1'b1;
			end else if (it.name_char == dqb_pkg::CH_DOT) begin
				if (lbl_len == 0) begin
					if (label_emitted)
						bad = 1'b1;
					else
						root_seen = 1'b1;
				end else begin
					flush_label();
				end
			end else begin
				bad = !store_char(it.name_char);
			end
		end

		// end of name: a dangling backslash stands for itself
		if (!bad && it.is_last) begin
			if (esc_pend) begin
				esc_pend = 1'b0;
				bad = !store_char(dqb_pkg::CH_BSL);
			end
			if (!bad) begin
				if (lbl_len > 0)
					flush_label();
				put_byte(8'h00);
				put_byte(it.query_type[15:8]);
				put_byte(it.query_type[7:0]);
				put_byte(it.query_class[15:8]);
				put_byte(it.query_class[7:0]);
				pack_bytes(1'b1);
				clear_msg();
				qcount++;
				return;
			end
		end

		// bad name: bytes so far, then one error pair
		if (bad) begin
			pack_bytes(1'b0);
			e.byte_first = 8'h00;
			e.byte_second = 8'h00;
			e.byte_count = dqb_pkg::BC_ERR;
			e.message_end = 1'b1;
			e.name_status = 1'b1;
			add_pair(e);
			clear_msg();
			if (it.is_last)
				qcount++;
			else
				skipping = 1'b1;
			return;
		end

		pack_bytes(1'b0);
	endfunction

	// turns name_buf into items, ending on the last character or on an end-only item
	function automatic void send_name(bit last_on_char, logic [15:0] qt, logic [15:0] qc);
		dqb_pkg::in_item_t it;
		for (int i = 0; i < name_buf.size(); i++) begin
			if (add_blanks && $urandom_range(0, 19) == 0) begin
				it.has_char = 1'b0;
				it.name_char = 8'($urandom_range(0, 255));
				it.is_last = 1'b0;
				it.query_type = 16'($urandom_range(0, 65535));
				it.query_class = 16'($urandom_range(0, 65535));
				add_item(it);
			end
			it.has_char = 1'b1;
			it.name_char = name_buf[i];
			it.is_last = last_on_char && (i == name_buf.size() - 1);
			it.query_type = it.is_last ? qt : 16'($urandom_range(0, 65535));
			it.query_class = it.is_last ? qc : 16'($urandom_range(0, 65535));
			add_item(it);
			items_made++;
		end
		if (!last_on_char || name_buf.size() == 0) begin
			it.has_char = 1'b0;
			it.name_char = 8'($urandom_range(0, 255));
			it.is_last = 1'b1;
			it.query_type = qt;
			it.query_class = qc;
			add_item(it);
			items_made++;
		end
	endfunction

	function automatic void load_text(string s);
		name_buf.delete();
		for (int i = 0; i < s.len(); i++)
			add_name_byte(s[i]);
	endfunction

	function automatic void push_letters(int n);
		repeat (n) add_name_byte(8'h61 + 8'($urandom_range(0, 25)));
	endfunction

	// random name: mostly well formed labels, some broken ones
	function automatic void build_random_name();
		int r;
		int n_lbl;
		int len;
		name_buf.delete();
		r = $urandom_range(0, 99);
		if (r < 4)
			return;
		if (r < 7) begin
			add_name_byte(dqb_pkg::CH_DOT);
			return;
		end
		n_lbl = $urandom_range(1, 4);
		for (int k = 0; k < n_lbl; k++) begin
			if (k > 0)
				add_name_byte(dqb_pkg::CH_DOT);
			len = $urandom_range(1, 6);
			for (int j = 0; j < len; j++) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					push_letters(1);
				end else if (r < 82) begin
					add_name_byte(dqb_pkg::CH_BSL);
					add_name_byte(8'($urandom_range(0, 255)));
				end else begin
					add_name_byte(8'($urandom_range(0, 255)));
				end
			end
		end
		r = $urandom_range(0, 99);
		if (r < 8)
			name_buf.insert($urandom_range(0, name_buf.size() - 1), dqb_pkg::CH_DOT);
		else if (r < 14)
			add_name_byte(dqb_pkg::CH_DOT);
		else if (r < 18)
			add_name_byte(dqb_pkg::CH_BSL);
	endfunction

	// register writes, only while nothing is in flight
	task automatic write_reg(logic [dqb_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		if (idx == dqb_pkg::CFG_RECURSION_DESIRED)
			rd_bit = val[0];
		else if (idx == dqb_pkg::CFG_ID_BASE)
			id_base_r = val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// wait until every item is in and every pair is out, then let the block settle
	task automatic wait_idle();
		do @(negedge clk);
		while (char_items.size() != 0 || in_valid || msg_pairs_due.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic random_names(int target);
		items_made = 0;
		while (items_made < target) begin
			build_random_name();
			send_name($urandom_range(0, 1), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 65535)));
		end
	endtask

	// stimulus
	initial begin
		rd_bit = 1'b1;
		id_base_r = 16'h0000;
		qcount = 16'h0000;
		skipping = 1'b0;
		clear_msg();
		gaps_on = 1'b1;
		add_blanks = 1'b0;
		bad_pairs = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed names under the reset settings
		@(negedge clk);
		name_buf.delete();
		send_name(1'b0, 16'h0000, 16'h0000);
		add_item('{has_char: 1'b0, name_char: 8'hFF, is_last: 1'b0,
			query_type: 16'hFFFF, query_class: 16'hFFFF});
		load_text("a");
		send_name(1'b1, 16'hFFFF, 16'hFFFF);
		load_text(".");
		send_name(1'b0, 16'h0001, 16'h0001);
		load_text(".a");
		send_name(1'b1, 16'h0002, 16'h0001);
		load_text("a..b");
		send_name(1'b1, 16'h001C, 16'h00FF);
		load_text("a\\");
		send_name(1'b0, 16'h8000, 16'h0080);
		load_text("\\.\\\\");
		send_name(1'b1, 16'h5555, 16'hAAAA);
		name_buf.delete();
		add_name_byte(8'h00);
		add_name_byte(8'hFF);
		add_name_byte(dqb_pkg::CH_DOT);
		add_name_byte(8'h7A);
		send_name(1'b1, 16'hAAAA, 16'h5555);
		load_text("ab.");
		send_name(1'b0, 16'h00FF, 16'hFF00);
		wait_idle();

		// long labels at and past the limit, back to back
		write_reg(dqb_pkg::CFG_RECURSION_DESIRED, 16'h0000);
		write_reg(dqb_pkg::CFG_ID_BASE, 16'hFFFF);
		gaps_on = 1'b0;
		@(negedge clk);
		name_buf.delete();
		push_letters(62);
		add_name_byte(dqb_pkg::CH_BSL);
		send_name(1'b0, 16'h000F, 16'h0001);
		name_buf.delete();
		push_letters(63);
		add_name_byte(dqb_pkg::CH_BSL);
		add_name_byte(dqb_pkg::CH_DOT);
		send_name(1'b1, 16'h0005, 16'h0001);
		wait_idle();

		// random names, first half
		write_reg(dqb_pkg::CFG_RECURSION_DESIRED, 16'h0001);
		write_reg(dqb_pkg::CFG_ID_BASE, 16'h0000);
		gaps_on = 1'b1;
		add_blanks = 1'b1;
		@(negedge clk);
		random_names(15);
		wait_idle();

		// random names, second half under random settings
		write_reg(dqb_pkg::CFG_RECURSION_DESIRED, 16'($urandom_range(0, 1)));
		write_reg(dqb_pkg::CFG_ID_BASE, 16'($urandom_range(0, 65535)));
		@(negedge clk);
		random_names(15);
		wait_idle();

		repeat (40) @(negedge clk);
		if (bad_pairs == 0 && msg_pairs_due.size() == 0)
			$display("PASS dns_query_builder");
		else
			$display("FAIL dns_query_builder");
		$finish;
	end

	// input driver: predicts on each accepted item, then offers the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_item <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				encode_item(in_item);
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (char_items.size() > 0) begin
					in_item <= char_items.pop_front();
					in_valid <= 1'b1;
					send_gap = gaps_on ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_cnt = 0;
		end else if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			hold_cnt = gaps_on ? pick_gap() : 0;
		end
	end

	// pair checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (msg_pairs_due.size() == 0) begin
				bad_pairs++;
				if (bad_pairs <= 10)
					$display("unexpected pair: first %h second %h count %0d end %b status %b",
						out_item.byte_first, out_item.byte_second, out_item.byte_count,
						out_item.message_end, out_item.name_status);
			end else begin
				want = msg_pairs_due.pop_front();
				if (out_item.byte_first !== want.byte_first
						|| out_item.byte_second !== want.byte_second
						|| out_item.byte_count !== want.byte_count
						|| out_item.message_end !== want.message_end
						|| out_item.name_status !== want.name_status) begin
					bad_pairs++;
					if (bad_pairs <= 10)
						$display("pair mismatch: want %h %h %0d %b %b, got %h %h %0d %b %b",
							want.byte_first, want.byte_second, want.byte_count,
							want.message_end, want.name_status,
							out_item.byte_first, out_item.byte_second, out_item.byte_count,
							out_item.message_end, out_item.name_status);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL dns_query_builder");
			$finish;
		end
	end

endmodule
